// File: hw/rtl/chacha_pkg.sv
// Shared types, constants and helpers for the ChaCha20 stream XOR core.
// No dependencies; used by chacha20_stream_xor_core.
package chacha_pkg;

  localparam int DOUBLE_ROUNDS_DEF = 10;

  localparam int WORD_W  = 32;
  localparam int CFG_W   = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W   = 3;
  localparam int BLK_WORDS = 16;
  localparam int POS_W   = 4;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_01   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_23   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_45   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_67   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_01 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_2  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTER  = 3'd6;

  localparam logic [WORD_W-1:0] SIGMA_0 = 32'h61707865;
  localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320646e;
  localparam logic [WORD_W-1:0] SIGMA_2 = 32'h79622d32;
  localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b206574;

  // 4x4 word matrix, word 4*row+col
  typedef logic [BLK_WORDS-1:0][WORD_W-1:0] blk_t;
  typedef logic [3:0][1:0] row_amt_t;

  // Per-row left rotations applied after each quarter round.
  // Plain step moves the next column into column 0; the other two also
  // enter / leave the diagonal arrangement.
  localparam row_amt_t AMT_NEXT_COL  = {2'd1, 2'd1, 2'd1, 2'd1};
  localparam row_amt_t AMT_TO_DIAG   = {2'd0, 2'd3, 2'd2, 2'd1};
  localparam row_amt_t AMT_FROM_DIAG = {2'd2, 2'd3, 2'd0, 2'd1};

  function automatic blk_t rot_rows(blk_t st, row_amt_t amt);
    blk_t res;
    logic [1:0] src;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        src = 2'(c) + amt[r];
        res[r*4+c] = st[{2'(r), src}];
      end
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/chacha20_stream_xor_core.sv
// ChaCha20 stream XOR core: keystream generator and data word XOR.
// Depends on chacha_pkg (types, register indexes, row rotation helper).
//
//  channel | ports                                         | transfer when
//  --------+-----------------------------------------------+------------------------
//  input   | in_valid/in_ready, in_data_in, in_byte_count, | in_valid & in_ready
//          | in_end_of_buffer                              |
//  output  | out_valid/out_ready, out_data_out,            | out_valid & out_ready
//          | out_byte_count, out_last                      |
//  config  | cfg_we, cfg_index, cfg_wdata                  | cfg_we (no wait)
//
// Sequence: a word that finds keystream held is accepted, then emitted.
// A word that starts a block first runs the DOUBLE_ROUNDS double rounds (one
// quarter-round half-step per cycle on the shared adder/rotate unit), then a
// final addition pass over the 16 words on that same adder.
// Reset clears all control state, counter, key and nonce; no clearing pass.
// A stalled output holds its register; the next word is still accepted and
// waits in the emit state until the output register frees up.
module chacha20_stream_xor_core #(
  parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [chacha_pkg::WORD_W-1:0]      in_data_in,
  input  logic [chacha_pkg::CNT_W-1:0]       in_byte_count,
  input  logic                               in_end_of_buffer,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [chacha_pkg::WORD_W-1:0]      out_data_out,
  output logic [chacha_pkg::CNT_W-1:0]       out_byte_count,
  output logic                               out_last,
  input  logic                               cfg_we,
  input  logic [chacha_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [chacha_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int DrW = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
  localparam logic [DrW-1:0] DR_LAST = DrW'(DOUBLE_ROUNDS - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_FINAL, ST_EMIT} fsm_t;

  fsm_t state_r, state_nxt;

  // configuration and block state
  logic [7:0][chacha_pkg::WORD_W-1:0] key_r, key_nxt;
  logic [2:0][chacha_pkg::WORD_W-1:0] nonce_r, nonce_nxt;
  logic [chacha_pkg::WORD_W-1:0]      ctr_r, ctr_nxt;
  logic [chacha_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic                               blk_ok_r, blk_ok_nxt;

  // working matrix; holds the keystream once a block is finished
  chacha_pkg::blk_t w_r, w_nxt;

  // sequencer counters: half-step, quarter round (column), half, double round
  logic [1:0]     step_r, step_nxt;
  logic [1:0]     qr_r, qr_nxt;
  logic           half_r, half_nxt;
  logic [DrW-1:0] dr_r, dr_nxt;

  // captured input word
  logic [chacha_pkg::WORD_W-1:0] data_r, data_nxt;
  logic [chacha_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                          last_r, last_nxt;

  // output register
  logic                          ovld_r, ovld_nxt;
  logic [chacha_pkg::WORD_W-1:0] odata_r, odata_nxt;
  logic [chacha_pkg::CNT_W-1:0]  ocnt_r, ocnt_nxt;
  logic                          olast_r, olast_nxt;

  chacha_pkg::blk_t              init_st;
  logic [chacha_pkg::POS_W-1:0]  fin_idx;
  logic [chacha_pkg::WORD_W-1:0] op_p, op_q, op_r, sum, mix, rot;
  logic [chacha_pkg::WORD_W-1:0] mask;
  chacha_pkg::blk_t              w_step;
  chacha_pkg::row_amt_t          amt;

  // initial matrix: constants, key, counter, nonce
  always_comb begin
    init_st[0] = chacha_pkg::SIGMA_0;
    init_st[1] = chacha_pkg::SIGMA_1;
    init_st[2] = chacha_pkg::SIGMA_2;
    init_st[3] = chacha_pkg::SIGMA_3;
    for (int i = 0; i < 8; i++) begin
      init_st[4+i] = key_r[i];
    end
    init_st[12] = ctr_r;
    for (int i = 0; i < 3; i++) begin
      init_st[13+i] = nonce_r[i];
    end
  end

  assign fin_idx = {qr_r, step_r};

  // shared unit: one add, xor, step-selected rotate. Even half-steps work a+=b,d;
  // odd ones c+=d,b. During the final pass it adds the initial word.
  always_comb begin
    if (state_r == ST_FINAL) begin
      op_p = w_r[0];
      op_q = init_st[fin_idx];
      op_r = w_r[12];
    end else if (step_r[0]) begin
      op_p = w_r[8];
      op_q = w_r[12];
      op_r = w_r[4];
    end else begin
      op_p = w_r[0];
      op_q = w_r[4];
      op_r = w_r[12];
    end
    sum = op_p + op_q;
    mix = op_r ^ sum;
    case (step_r)
      2'd0:    rot = {mix[15:0], mix[31:16]};
      2'd1:    rot = {mix[19:0], mix[31:20]};
      2'd2:    rot = {mix[23:0], mix[31:24]};
      default: rot = {mix[24:0], mix[31:25]};
    endcase
  end

  always_comb begin
    w_step = w_r;
    if (step_r[0]) begin
      w_step[8] = sum;
      w_step[4] = rot;
    end else begin
      w_step[0] = sum;
      w_step[12] = rot;
    end
    if (qr_r != 2'd3) begin
      amt = chacha_pkg::AMT_NEXT_COL;
    end else if (!half_r) begin
      amt = chacha_pkg::AMT_TO_DIAG;
    end else begin
      amt = chacha_pkg::AMT_FROM_DIAG;
    end
  end

  always_comb begin
    case (cnt_r)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    key_nxt    = key_r;
    nonce_nxt  = nonce_r;
    ctr_nxt    = ctr_r;
    pos_nxt    = pos_r;
    blk_ok_nxt = blk_ok_r;
    w_nxt      = w_r;
    step_nxt   = step_r;
    qr_nxt     = qr_r;
    half_nxt   = half_r;
    dr_nxt     = dr_r;
    data_nxt   = data_r;
    cnt_nxt    = cnt_r;
    last_nxt   = last_r;
    ovld_nxt   = ovld_r && !out_ready;
    odata_nxt  = odata_r;
    ocnt_nxt   = ocnt_r;
    olast_nxt  = olast_r;

    if (cfg_we) begin
      unique case (cfg_index)
        chacha_pkg::CFG_KEY_01: begin
          key_nxt[0] = cfg_wdata[31:0];
          key_nxt[1] = cfg_wdata[63:32];
        end
        chacha_pkg::CFG_KEY_23: begin
          key_nxt[2] = cfg_wdata[31:0];
          key_nxt[3] = cfg_wdata[63:32];
        end
        chacha_pkg::CFG_KEY_45: begin
          key_nxt[4] = cfg_wdata[31:0];
          key_nxt[5] = cfg_wdata[63:32];
        end
        chacha_pkg::CFG_KEY_67: begin
          key_nxt[6] = cfg_wdata[31:0];
          key_nxt[7] = cfg_wdata[63:32];
        end
        chacha_pkg::CFG_NONCE_01: begin
          nonce_nxt[0] = cfg_wdata[31:0];
          nonce_nxt[1] = cfg_wdata[63:32];
        end
        chacha_pkg::CFG_NONCE_2: begin
          nonce_nxt[2] = cfg_wdata[31:0];
        end
        chacha_pkg::CFG_COUNTER: begin
          ctr_nxt = cfg_wdata[31:0];
        end
        default: begin
        end
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          data_nxt = in_data_in;
          cnt_nxt  = in_byte_count;
          last_nxt = in_end_of_buffer;
          if (blk_ok_r) begin
            state_nxt = ST_EMIT;
          end else begin
            w_nxt     = init_st;
            step_nxt  = 2'd0;
            qr_nxt    = 2'd0;
            half_nxt  = 1'b0;
            dr_nxt    = '0;
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) begin
          w_nxt  = chacha_pkg::rot_rows(w_step, amt);
          qr_nxt = qr_r + 2'd1;
          if (qr_r == 2'd3) begin
            half_nxt = !half_r;
            if (half_r) begin
              dr_nxt = dr_r + DrW'(1);
              if (dr_r == DR_LAST) begin
                state_nxt = ST_FINAL;
              end
            end
          end
        end else begin
          w_nxt = w_step;
        end
      end
      ST_FINAL: begin
        // rotate the matrix through word 0, adding the initial word
        for (int i = 0; i < chacha_pkg::BLK_WORDS - 1; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[chacha_pkg::BLK_WORDS-1] = sum;
        {qr_nxt, step_nxt} = fin_idx + 4'd1;
        if (fin_idx == 4'd15) begin
          ctr_nxt    = ctr_r + 32'd1;
          blk_ok_nxt = 1'b1;
          pos_nxt    = '0;
          state_nxt  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!ovld_r || out_ready) begin
          ovld_nxt  = 1'b1;
          odata_nxt = (data_r ^ w_r[pos_r]) & mask;
          ocnt_nxt  = cnt_r;
          olast_nxt = last_r;
          pos_nxt   = pos_r + 4'd1;
          if (last_r || pos_r == 4'd15) begin
            pos_nxt    = '0;
            blk_ok_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      key_r    <= '0;
      nonce_r  <= '0;
      ctr_r    <= '0;
      pos_r    <= '0;
      blk_ok_r <= 1'b0;
      step_r   <= '0;
      qr_r     <= '0;
      half_r   <= 1'b0;
      dr_r     <= '0;
      ovld_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      key_r    <= key_nxt;
      nonce_r  <= nonce_nxt;
      ctr_r    <= ctr_nxt;
      pos_r    <= pos_nxt;
      blk_ok_r <= blk_ok_nxt;
      step_r   <= step_nxt;
      qr_r     <= qr_nxt;
      half_r   <= half_nxt;
      dr_r     <= dr_nxt;
      ovld_r   <= ovld_nxt;
    end
    w_r     <= w_nxt;
    data_r  <= data_nxt;
    cnt_r   <= cnt_nxt;
    last_r  <= last_nxt;
    odata_r <= odata_nxt;
    ocnt_r  <= ocnt_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid      = ovld_r;
  assign out_data_out   = odata_r;
  assign out_byte_count = ocnt_r;
  assign out_last       = olast_r;

endmodule
